FILE: rtl/weighted_symbol_probability_estimator_assert.svh
// Assertion macros for the weighted symbol probability estimator.
// Used by the port checker; needs a clock named clock and a reset named reset in scope.
`ifndef WEIGHTED_SYMBOL_PROBABILITY_ESTIMATOR_ASSERT_SVH
`define WEIGHTED_SYMBOL_PROBABILITY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define WSPE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wspe assertion failed");

// Next-cycle implication, held off while reset is high.
`define WSPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wspe assertion failed");

`endif

FILE: rtl/wspe_pkg.sv
// Shared types and constants of the weighted symbol probability estimator.
// No dependencies; used by every other file of the block except the assertion header.
package wspe_pkg;

   localparam int MAX_CLASSES = 256;
   localparam int CLASS_AW    = $clog2(MAX_CLASSES);
   localparam int NEFF_W      = CLASS_AW + 1;

   localparam int MODE_W   = 2;
   localparam int SYMBOL_W = 8;
   localparam int WEIGHT_W = 16;
   localparam int NCLS_W   = 9;
   localparam int PRIOR_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int TOTAL_W  = 40;
   localparam int PROB_W   = 16;

   localparam int QUOT_BITS = 16;
   localparam int STEP_W    = $clog2(QUOT_BITS);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIOR_COUNT = 1'b1;

   localparam logic [NCLS_W-1:0]  NCLS_RESET  = 9'd256;
   localparam logic [PRIOR_W-1:0] PRIOR_RESET = 16'd256;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [PROB_W-1:0]  PROB_MAX  = '1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SYMBOL_W-1:0] symbol;
      logic [WEIGHT_W-1:0] weight;
   } wspe_req_type;

   typedef struct packed {
      logic [PROB_W-1:0]  probability;
      logic               in_range;
      logic [TOTAL_W-1:0] total_count;
   } wspe_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } wspe_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } wspe_div_status_type;

endpackage

FILE: rtl/wspe_div.sv
// Restoring divider: (count << 16) / total for count below total, one quotient bit a cycle.
// Depends on wspe_pkg.
module wspe_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wspe_pkg::COUNT_W-1:0]     dividend,
   input  logic [wspe_pkg::TOTAL_W-1:0]     divisor,
   output wspe_pkg::wspe_div_status_type    status,
   output logic [wspe_pkg::QUOT_BITS-1:0]   quotient
);
   import wspe_pkg::*;

   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TOTAL_W:0]     rem_dbl;
   logic [TOTAL_W:0]     rem_diff;
   logic                 fits;

   always_comb begin
      rem_dbl  = {rem_ff, 1'b0};
      rem_diff = rem_dbl - {1'b0, divisor};
      fits     = (rem_dbl >= {1'b0, divisor});
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in  = TOTAL_W'(dividend);
         quot_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the doubled value fits in TOTAL_W+1 bits
         rem_in  = fits ? rem_diff[TOTAL_W-1:0] : rem_dbl[TOTAL_W-1:0];
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

FILE: rtl/weighted_symbol_probability_estimator.sv
// Weighted symbol probability estimator: weighted histogram with a prior count.
// Depends on wspe_pkg and wspe_div.
//
// Usage:
//  - req channel (req_valid / req_stall / req_payload) carries one item per transfer:
//    mode add, query or clear, a symbol and a Q8.8 weight.
//  - rsp channel (rsp_valid / rsp_stall / rsp_payload) returns exactly one result per
//    item: Q0.16 probability (queries only), in_range flag and the Q32.8 running total.
//  - csr channel (csr_valid / csr_ready / csr_index / csr_data) writes num_classes
//    (index 0) and prior_count (index 1); write only while the block is idle.
//  - One item is in flight at a time. Counts live in a 256 x 32 synchronous RAM with
//    a registered read; the item reads its entry, then modifies and writes it back.
//  - An item passes through LOOKUP, then DIVIDE for a query that uses the bit-serial
//    divider, then FINISH, which loads the result into the output register.
//  - A new item is accepted only after the previous one has left FINISH.
//  - A finished result sits in the output register; if rsp_stall holds it, the block
//    finishes the next item internally and waits to hand it over.
//  - Reset clears the total, marks every RAM entry invalid (reads as zero) and sets
//    num_classes and prior_count to 256. A clear marks all entries invalid again and
//    makes an invalid entry read as the prior, without writing the RAM.
module weighted_symbol_probability_estimator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wspe_pkg::wspe_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wspe_pkg::wspe_rsp_type              rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wspe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wspe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import wspe_pkg::*;

   // control
   wspe_state_type          state_ff, state_in;
   logic                    req_accept;
   logic                    csr_write;
   logic                    mem_we;
   logic                    clear_go;
   logic                    add_go;
   logic                    div_start;
   logic                    rsp_load;

   // configuration
   logic [NCLS_W-1:0]       ncls_ff, ncls_in;
   logic [PRIOR_W-1:0]      prior_ff, prior_in;
   logic [NEFF_W-1:0]       n_eff;

   // item held while in flight
   logic [MODE_W-1:0]       mode_ff;
   logic [CLASS_AW-1:0]     addr_ff;
   logic [WEIGHT_W-1:0]     weight_ff;
   logic                    ok_ff, ok_in;
   logic [PROB_W-1:0]       prob_ff, prob_in;

   // count store and its state
   logic [COUNT_W-1:0]      class_mem [MAX_CLASSES];
   logic [COUNT_W-1:0]      rd_data_ff;
   logic [CLASS_AW-1:0]     rd_addr;
   logic [MAX_CLASSES-1:0]  valid_ff, valid_in;
   logic [PRIOR_W-1:0]      fill_ff, fill_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;

   // datapath
   logic [COUNT_W-1:0]          cur_count;
   logic [COUNT_W:0]            count_sum;
   logic [COUNT_W-1:0]          count_new;
   logic [TOTAL_W:0]            total_sum;
   logic [TOTAL_W-1:0]          total_new;
   logic [PRIOR_W+NEFF_W-1:0]   clear_prod;

   // divider
   wspe_div_status_type     div_status;
   logic [QUOT_BITS-1:0]    div_quot;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   wspe_rsp_type            rsp_payload_ff, rsp_payload_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rd_addr    = CLASS_AW'(req_payload.symbol);

   // classes in use: num_classes clamped to the store depth
   always_comb begin
      if (32'(ncls_ff) > 32'(MAX_CLASSES)) begin
         n_eff = NEFF_W'(MAX_CLASSES);
      end else begin
         n_eff = NEFF_W'(ncls_ff);
      end
   end

   // an entry not written since the last clear (or reset) reads as the fill value
   assign cur_count = valid_ff[addr_ff] ? rd_data_ff : COUNT_W'(fill_ff);
   assign count_sum = {1'b0, cur_count} + (COUNT_W + 1)'(weight_ff);
   assign count_new = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(weight_ff);
   assign total_new = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
   assign clear_prod = (PRIOR_W + NEFF_W)'(prior_ff) * (PRIOR_W + NEFF_W)'(n_eff);

   wspe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur_count),
      .divisor  (total_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   // sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      clear_go  = 1'b0;
      add_go    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      prob_in   = prob_ff;
      ok_in     = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ok_in    = (32'(req_payload.symbol) < 32'(n_eff));
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // read data for the held symbol is valid this cycle
            prob_in  = '0;
            state_in = ST_FINISH;
            case (mode_ff)
               MODE_ADD: begin
                  if (ok_ff) begin
                     mem_we = 1'b1;
                     add_go = 1'b1;
                  end
               end
               MODE_QUERY: begin
                  if (ok_ff && (total_ff != '0)) begin
                     if (TOTAL_W'(cur_count) >= total_ff) begin
                        // quotient would reach 2^16: saturate
                        prob_in = PROB_MAX;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end
                  end
               end
               MODE_CLEAR: begin
                  clear_go = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               prob_in  = div_quot;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // store state, configuration and output next values
   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      ncls_in  = ncls_ff;
      prior_in = prior_ff;
      if (add_go) begin
         valid_in[addr_ff] = 1'b1;
         total_in          = total_new;
      end
      if (clear_go) begin
         valid_in = '0;
         fill_in  = prior_ff;
         total_in = TOTAL_W'(clear_prod);
      end
      if (csr_write) begin
         case (csr_index)
            CSR_NUM_CLASSES: ncls_in  = csr_data[NCLS_W-1:0];
            CSR_PRIOR_COUNT: prior_in = csr_data[PRIOR_W-1:0];
            default: begin
            end
         endcase
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.probability = prob_ff;
         rsp_payload_in.in_range    = ok_ff;
         rsp_payload_in.total_count = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         ncls_ff      <= NCLS_RESET;
         prior_ff     <= PRIOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         ncls_ff      <= ncls_in;
         prior_ff     <= prior_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff          <= ok_in;
      prob_ff        <= prob_in;
      rsp_payload_ff <= rsp_payload_in;
      if (req_accept) begin
         mode_ff   <= req_payload.mode;
         addr_ff   <= rd_addr;
         weight_ff <= req_payload.weight;
      end
   end

   // count RAM: one write port, one registered read port; the sequencer keeps
   // a single item in flight, so a read never overlaps a pending write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         class_mem[addr_ff] <= count_new;
      end
      rd_data_ff <= class_mem[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/wspe_checker.sv
// Port-level checker for the weighted symbol probability estimator, bound to the top level.
// Depends on wspe_pkg and weighted_symbol_probability_estimator_assert.svh.
`include "weighted_symbol_probability_estimator_assert.svh"

module wspe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input wspe_pkg::wspe_req_type              req_payload,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input wspe_pkg::wspe_rsp_type              rsp_payload,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [wspe_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [wspe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import wspe_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_payload, csr_valid, csr_ready, csr_index, csr_data};

   // stalled result holds
   `WSPE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   // one item in flight: the cycle after a transfer the input is stalled
   `WSPE_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)
   // out-of-range symbols never get a probability
   `WSPE_ASSERT_NOW(a_range_zero, rsp_valid && !rsp_payload.in_range,
                    rsp_payload.probability == '0)
   // a nonzero probability needs a nonzero total
   `WSPE_ASSERT_NOW(a_prob_total, rsp_valid && (rsp_payload.probability != '0),
                    rsp_payload.total_count != '0)

endmodule

bind weighted_symbol_probability_estimator wspe_checker u_wspe_checker (.*);

FILE: test/weighted_symbol_probability_estimator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the weighted symbol probability estimator top level.
// Needs wspe_pkg and the block's RTL; it predicts every result and compares each field.
module weighted_symbol_probability_estimator_test;
   import wspe_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int RESET_TICKS = 6;
   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_TICKS = 30;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 125;
   // The package names only three modes; the fourth encoding is a no-op.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid   = 1'b0;
   logic         req_stall;
   wspe_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   wspe_rsp_type rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Shadow copy of the histogram, the total and the two registers.
   logic [COUNT_W-1:0] class_tally [MAX_CLASSES];
   logic [TOTAL_W-1:0] running_total;
   logic [NCLS_W-1:0]  cfg_classes;
   logic [PRIOR_W-1:0] cfg_prior;

   wspe_req_type pending_requests[$];
   wspe_rsp_type expected_estimates[$];
   int unsigned  requests_issued = 0;
   int unsigned  results_checked = 0;
   int unsigned  error_count     = 0;
   int unsigned  cycle_count     = 0;
   int unsigned  send_gap        = 0;
   int unsigned  stall_left      = 0;
   logic         req_calm        = 1'b0;
   logic         rsp_calm        = 1'b0;

   weighted_symbol_probability_estimator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Number of classes that actually take part: num_classes capped at the store depth.
   function automatic int unsigned active_classes();
      return (cfg_classes > MAX_CLASSES) ? MAX_CLASSES : int'(cfg_classes);
   endfunction

   // Advance the shadow histogram by one item and return the result it must produce.
   function automatic wspe_rsp_type estimate_result(input wspe_req_type item);
      wspe_rsp_type            res;
      logic                    hit;
      logic [COUNT_W:0]        count_sum;
      logic [TOTAL_W:0]        total_sum;
      logic [COUNT_W+PROB_W-1:0] scaled;
      logic [COUNT_W+PROB_W-1:0] ratio;
      res = '0;
      hit = int'(item.symbol) < active_classes();
      case (item.mode)
         MODE_ADD: begin
            if (hit) begin
               count_sum = {1'b0, class_tally[item.symbol]} + (COUNT_W + 1)'(item.weight);
               class_tally[item.symbol] = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
               total_sum = {1'b0, running_total} + (TOTAL_W + 1)'(item.weight);
               running_total = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            end
         end
         MODE_QUERY: begin
            // Count over total as Q0.16, truncated; a count at or above the total
            // (possible after a clear with few classes) pins at full scale.
            if (hit && running_total != '0) begin
               scaled = {class_tally[item.symbol], {PROB_W{1'b0}}};
               ratio  = scaled / {{(COUNT_W+PROB_W-TOTAL_W){1'b0}}, running_total};
               res.probability = (ratio > (COUNT_W + PROB_W)'(PROB_MAX)) ?
                                 PROB_MAX : ratio[PROB_W-1:0];
            end
         end
         MODE_CLEAR: begin
            // Every entry takes the prior, but only the classes in use enter the total.
            for (int i = 0; i < MAX_CLASSES; i++) class_tally[i] = COUNT_W'(cfg_prior);
            running_total = TOTAL_W'(cfg_prior) * TOTAL_W'(active_classes());
         end
         default: ;
      endcase
      res.in_range    = hit;
      res.total_count = running_total;
      return res;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: hold the payload until the transfer, then insert a gap
   // and fetch the next pending request. Predict at the moment of transfer.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic hold;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         hold = req_valid;
         if (req_valid && !req_stall) begin
            expected_estimates.push_back(estimate_result(req_payload));
            hold = 1'b0;
         end
         if (!hold) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
               send_gap = req_calm ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: check each transfer against the oldest prediction and
   // throw in stall stretches of random length.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      wspe_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_estimates.size() == 0) begin
               $error("result transfer with no prediction pending: total_count %0d",
                      rsp_payload.total_count);
               error_count++;
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_payload.probability !== want.probability) begin
                  $error("probability: expected %0d, got %0d",
                         want.probability, rsp_payload.probability);
                  error_count++;
               end
               if (rsp_payload.in_range !== want.in_range) begin
                  $error("in_range: expected %0d, got %0d", want.in_range, rsp_payload.in_range);
                  error_count++;
               end
               if (rsp_payload.total_count !== want.total_count) begin
                  $error("total_count: expected %0d, got %0d",
                         want.total_count, rsp_payload.total_count);
                  error_count++;
               end
               results_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!rsp_calm && $urandom_range(3) == 0) begin
            stall_left = idle_len();
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("weighted_symbol_probability_estimator_test: FAIL");
         $finish;
      end
   end

   task automatic queue_request(input logic [MODE_W-1:0] mode,
                                input logic [SYMBOL_W-1:0] symbol,
                                input logic [WEIGHT_W-1:0] weight);
      wspe_req_type item;
      item.mode   = mode;
      item.symbol = symbol;
      item.weight = weight;
      pending_requests.push_back(item);
      requests_issued++;
   endtask

   // Wait until every issued request has come back, then let the block settle.
   task automatic wait_for_results();
      while (results_checked != requests_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the shadow copy follows at the transfer edge.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_NUM_CLASSES) cfg_classes = value[NCLS_W-1:0];
      else cfg_prior = value[PRIOR_W-1:0];
   endtask

   // Write both registers, in random order.
   task automatic set_config(input logic [NCLS_W-1:0] classes,
                             input logic [PRIOR_W-1:0] prior);
      if ($urandom_range(1)) begin
         write_csr(CSR_NUM_CLASSES, CSR_DATA_W'(classes));
         write_csr(CSR_PRIOR_COUNT, prior);
      end else begin
         write_csr(CSR_PRIOR_COUNT, prior);
         write_csr(CSR_NUM_CLASSES, CSR_DATA_W'(classes));
      end
   endtask

   // Random request: mostly adds and queries on classes in use, with some
   // out-of-range symbols, occasional clears and the unused mode.
   function automatic wspe_req_type random_request();
      wspe_req_type item;
      int unsigned  pick;
      int unsigned  active;
      active = active_classes();
      pick = $urandom_range(99);
      if (pick < 50)      item.mode = MODE_ADD;
      else if (pick < 92) item.mode = MODE_QUERY;
      else if (pick < 96) item.mode = MODE_CLEAR;
      else                item.mode = MODE_UNUSED;
      if (active > 0 && $urandom_range(9) < 8) item.symbol = SYMBOL_W'($urandom_range(active - 1));
      else item.symbol = SYMBOL_W'($urandom);
      case ($urandom_range(3))
         0:       item.weight = WEIGHT_W'($urandom);
         1:       item.weight = WEIGHT_W'($urandom_range(1023));
         2:       item.weight = $urandom_range(1) ? '1 : '0;
         default: item.weight = WEIGHT_W'($urandom_range(4095, 256));
      endcase
      return item;
   endfunction

   initial begin
      logic [NCLS_W-1:0]  classes;
      logic [PRIOR_W-1:0] prior;
      for (int i = 0; i < MAX_CLASSES; i++) class_tally[i] = '0;
      running_total = '0;
      cfg_classes   = NCLS_RESET;
      cfg_prior     = PRIOR_RESET;

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // Reset values: empty histogram, 256 classes, Laplace prior.
      queue_request(MODE_QUERY,  8'd0,   16'd0);     // zero total
      queue_request(MODE_ADD,    8'd0,   16'hFFFF);
      queue_request(MODE_ADD,    8'd255, 16'd0);
      queue_request(MODE_ADD,    8'd255, 16'd1);
      queue_request(MODE_QUERY,  8'd0,   16'd0);
      queue_request(MODE_QUERY,  8'd255, 16'hFFFF);
      queue_request(MODE_UNUSED, 8'd7,   16'hFFFF);
      queue_request(MODE_CLEAR,  8'd0,   16'd0);
      queue_request(MODE_QUERY,  8'd3,   16'd0);
      queue_request(MODE_ADD,    8'd128, 16'h8000);
      wait_for_results();

      // One class with the largest prior: the count equals the total.
      set_config(9'd1, 16'hFFFF);
      queue_request(MODE_CLEAR,  8'd9,   16'd0);
      queue_request(MODE_QUERY,  8'd0,   16'd0);
      queue_request(MODE_QUERY,  8'd1,   16'd0);     // out of range
      queue_request(MODE_ADD,    8'd1,   16'h1234);  // ignored
      queue_request(MODE_ADD,    8'd0,   16'h1234);
      wait_for_results();

      // No class in use: nothing is in range, a clear zeroes the total.
      set_config(9'd0, 16'h0100);
      queue_request(MODE_QUERY,  8'd0,   16'd0);
      queue_request(MODE_CLEAR,  8'd0,   16'd0);
      queue_request(MODE_ADD,    8'd0,   16'hFFFF);
      queue_request(MODE_QUERY,  8'd0,   16'd0);
      wait_for_results();

      // Oversized class count capped at the store depth, zero prior.
      set_config(9'd300, 16'd0);
      queue_request(MODE_CLEAR,  8'd255, 16'd0);
      queue_request(MODE_QUERY,  8'd255, 16'd0);
      queue_request(MODE_ADD,    8'd255, 16'd5);
      queue_request(MODE_QUERY,  8'd255, 16'd0);
      wait_for_results();

      // Widen the class count after a clear: entries outside the total hold the prior.
      set_config(9'd2, 16'h4000);
      queue_request(MODE_CLEAR,  8'd0,   16'd0);
      wait_for_results();
      set_config(9'd200, 16'h4000);
      queue_request(MODE_QUERY,  8'd150, 16'd0);
      queue_request(MODE_QUERY,  8'd199, 16'd0);
      wait_for_results();

      // Random phases: new settings each time, usually a clear first, then
      // a stream of adds and queries under varying back-pressure.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       classes = 9'd1;
            1:       classes = 9'd256;
            2:       classes = 9'd511;
            3:       classes = 9'd0;
            4:       classes = 9'd2;
            default: classes = $urandom_range(3) == 0 ? 9'($urandom) : 9'($urandom_range(64, 1));
         endcase
         case (ph)
            0:       prior = 16'hFFFF;
            1:       prior = 16'd0;
            2:       prior = 16'd1;
            3:       prior = 16'd256;
            default: prior = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024));
         endcase
         set_config(classes, prior);
         req_calm = ($urandom_range(3) == 0);
         rsp_calm = ($urandom_range(3) == 0);
         if ($urandom_range(3) != 0) queue_request(MODE_CLEAR, 8'($urandom), 16'($urandom));
         // Fill the queue item by item so the symbols follow the current settings.
         for (int n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(random_request());
         requests_issued += PHASE_ITEMS;
         wait_for_results();
      end

      req_calm = 1'b0;
      rsp_calm = 1'b0;
      repeat (DRAIN_TICKS) @(posedge clock);
      if (expected_estimates.size() != 0) begin
         $error("%0d predicted results never arrived", expected_estimates.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("weighted_symbol_probability_estimator_test: PASS");
      end else begin
         $display("weighted_symbol_probability_estimator_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wspe_pkg.sv
rtl/wspe_div.sv
rtl/weighted_symbol_probability_estimator.sv
rtl/wspe_checker.sv
test/weighted_symbol_probability_estimator_test.sv
